// File: rtl/triangle_coverage_rasterizer_defines.svh
// Assertion helpers for the triangle coverage rasterizer.
// Each check is sampled on the rising clock edge and is held off while reset is asserted.
`ifndef TRIANGLE_COVERAGE_RASTERIZER_DEFINES_SVH
`define TRIANGLE_COVERAGE_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS

// The antecedent implies the consequent in the same cycle.
`define TCR_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tcr check failed");

// The antecedent implies the consequent in the next cycle.
`define TCR_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tcr check failed");

`else

`define TCR_ASSERT_IMP(name, clk, rstn, ante, cons)
`define TCR_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/tcr_pkg.sv
package tcr_pkg;

    // Fixed field widths
    localparam int VERT_W   = 16;
    localparam int DIFF_W   = VERT_W + 2;   // doubled vertex difference
    localparam int KIND_W   = 2;
    localparam int CFG_W    = 9;
    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 8;

    localparam logic [CFG_W-1:0] SIDE_RESET = 9'd256;

    // Operation kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Tags of the multiply-accumulate results
    localparam logic [1:0] TAG_AREA = 2'd0;
    localparam logic [1:0] TAG_W0   = 2'd1;
    localparam logic [1:0] TAG_W1   = 2'd2;
    localparam logic [1:0] TAG_W2   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_BOX,
        S_CLIP,
        S_SETUP,
        S_ROWRD,
        S_SCAN,
        S_ROWWR,
        S_READ,
        S_OUT
    } state_t;

    // Issue side of the shared multiplier
    typedef struct packed {
        logic       valid;
        logic       first;  // load product, else subtract it
        logic [1:0] tag;
    } mac_ctl_t;

    // Result side: accumulator holds a finished two-term difference
    typedef struct packed {
        logic       valid;
        logic [1:0] tag;
    } mac_res_t;

    function automatic logic signed [VERT_W-1:0] min3(
        input logic signed [VERT_W-1:0] a,
        input logic signed [VERT_W-1:0] b,
        input logic signed [VERT_W-1:0] c
    );
        logic signed [VERT_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [VERT_W-1:0] max3(
        input logic signed [VERT_W-1:0] a,
        input logic signed [VERT_W-1:0] b,
        input logic signed [VERT_W-1:0] c
    );
        logic signed [VERT_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

// File: rtl/tcr_mac.sv
module tcr_mac #(
    parameter int DW = 18,
    parameter int QW = 23,
    parameter int EW = 42
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcr_pkg::mac_ctl_t    ctl,
    input  logic signed [DW-1:0] op_a,
    input  logic signed [QW-1:0] op_b,
    output tcr_pkg::mac_res_t    res,
    output logic signed [EW-1:0] acc
);
    import tcr_pkg::*;

    localparam int MW = DW + QW;

    logic signed [MW-1:0] prod;
    logic signed [MW-1:0] prod_reg;
    logic signed [EW-1:0] acc_reg, acc_next;
    mac_ctl_t             pctl_reg;
    mac_res_t             res_reg, res_next;

    // Multiply stage
    assign prod = op_a * op_b;

    // Accumulate stage: first term loads, second term subtracts
    always_comb begin
        acc_next = acc_reg;
        if (pctl_reg.valid) begin
            if (pctl_reg.first) begin
                acc_next = EW'(prod_reg);
            end else begin
                acc_next = acc_reg - EW'(prod_reg);
            end
        end
        res_next.valid = pctl_reg.valid && !pctl_reg.first;
        res_next.tag   = pctl_reg.tag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pctl_reg <= '0;
            res_reg  <= '0;
        end else begin
            pctl_reg <= ctl;
            res_reg  <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod;
        acc_reg  <= acc_next;
    end

    assign res = res_reg;
    assign acc = acc_reg;

endmodule

// File: rtl/tcr_mem.sv
module tcr_mem #(
    parameter int SIDE = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(SIDE)-1:0]  wr_addr,
    input  logic [SIDE-1:0]          wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(SIDE)-1:0]  rd_addr,
    output logic [SIDE-1:0]          rd_data
);
    import tcr_pkg::*;

    // One word per mask row
    logic [SIDE-1:0] row_mem [SIDE];
    logic [SIDE-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= row_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/triangle_coverage_rasterizer.sv
// Triangle coverage rasterizer: a MASK_SIDE x MASK_SIDE one-bit mask held in a row-wide memory.
// Each transaction has a kind in s_tuser: clear, fill a triangle, or read one texel. Every
// transaction returns exactly one result, with the kind echoed on m_tuser and the read bit
// on m_tdata[0]. s_tready is high only while the block is idle.
//
// Operation:
// - After reset, a clearing pass runs before the first transaction.
// - A clear also writes zeros, one row per cycle.
// - A read fetches the addressed row, then picks out the texel; a read outside the side returns zero.
// - A fill runs box and edge setup, then reads, scans and writes back each row
//   of the clipped bounding box.
//
// The setup stage uses one shared 18 x QW-bit multiplier to form the area and one value
// per triangle edge. The scan then tests one texel per cycle with incremental adds, and each
// row is read, updated and written back through the memory's read and write ports.
// The user must write side_in_use (cfg_we / cfg_wdata) only while idle; the block does not enforce this.
`include "triangle_coverage_rasterizer_defines.svh"

module triangle_coverage_rasterizer #(
    parameter int MASK_SIDE = 256,
    parameter int FRAC_BITS = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // side_in_use register
    input  logic                           cfg_we,
    input  logic [tcr_pkg::CFG_W-1:0]      cfg_wdata,
    // input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, read_col, read_row
    input  logic [tcr_pkg::S_DATA_W-1:0]   s_tdata,
    // kind
    input  logic [tcr_pkg::KIND_W-1:0]     s_tuser,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // covered, zero fill
    output logic [tcr_pkg::M_DATA_W-1:0]   m_tdata,
    // done_kind
    output logic [tcr_pkg::KIND_W-1:0]     m_tuser
);
    import tcr_pkg::*;

    localparam int AW     = $clog2(MASK_SIDE);
    localparam int SDW    = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int LW     = ((SDW > VERT_W + 1) ? SDW : VERT_W + 1) + 1;
    localparam int RCW    = (AW > 8) ? AW : 8;
    localparam int DW     = DIFF_W;
    localparam int PW     = AW + FRAC_BITS + 2;
    localparam int QW     = ((PW > VERT_W + 1) ? PW : VERT_W + 1) + 1;
    localparam int EW     = DW + QW + 1;
    localparam int ONE_M1 = (1 << FRAC_BITS) - 1;

    // ---------------- registers ----------------
    state_t                   state_reg, state_next;
    logic [CFG_W-1:0]         side_reg, side_next;
    logic                     clr_reply_reg, clr_reply_next;
    logic [AW-1:0]            clr_row_reg, clr_row_next;
    logic [3:0]               issue_reg, issue_next;

    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic                     covered_reg, covered_next;
    logic [AW-1:0]            col_reg, col_next;
    logic signed [VERT_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [VERT_W-1:0] ax_next, ay_next, bx_next, by_next, cx_next, cy_next;
    logic signed [VERT_W-1:0] minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic signed [VERT_W-1:0] minx_next, maxx_next, miny_next, maxy_next;
    logic [AW-1:0]            x0_reg, x1_reg, y1_reg, x_reg, y_reg;
    logic [AW-1:0]            x0_next, x1_next, y1_next, x_next, y_next;
    logic signed [EW-1:0]     area_reg, area_next;
    logic signed [EW-1:0]     cur_reg [3];
    logic signed [EW-1:0]     cur_next [3];
    logic signed [EW-1:0]     rs_reg [3];
    logic signed [EW-1:0]     rs_next [3];
    logic signed [EW-1:0]     xstep_reg [3];
    logic signed [EW-1:0]     xstep_next [3];
    logic signed [EW-1:0]     ystep_reg [3];
    logic signed [EW-1:0]     ystep_next [3];
    logic [MASK_SIDE-1:0]     mask_reg, mask_next;

    // ---------------- input unpacking ----------------
    logic signed [VERT_W-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
    logic [7:0]               in_col, in_row;
    logic [RCW-1:0]           col_ext, row_ext;

    assign in_ax   = s_tdata[15:0];
    assign in_ay   = s_tdata[31:16];
    assign in_bx   = s_tdata[47:32];
    assign in_by   = s_tdata[63:48];
    assign in_cx   = s_tdata[79:64];
    assign in_cy   = s_tdata[95:80];
    assign in_col  = s_tdata[103:96];
    assign in_row  = s_tdata[111:104];
    assign col_ext = RCW'(in_col);
    assign row_ext = RCW'(in_row);

    // Effective side, min(side_in_use, MASK_SIDE)
    logic [SDW-1:0] eff_side;
    logic           rd_in_range;

    assign eff_side    = (SDW'(side_reg) < SDW'(MASK_SIDE)) ? SDW'(side_reg) : SDW'(MASK_SIDE);
    assign rd_in_range = (SDW'(in_col) < eff_side) && (SDW'(in_row) < eff_side);

    // ---------------- bounding box clip ----------------
    logic signed [LW-1:0] fx0, fx1, fy0, fy1, lim, cx0, cx1, cy0, cy1;
    logic                 box_empty;

    assign fx0 = LW'(minx_reg) >>> FRAC_BITS;
    assign fy0 = LW'(miny_reg) >>> FRAC_BITS;
    assign fx1 = (LW'(maxx_reg) + LW'(ONE_M1)) >>> FRAC_BITS;
    assign fy1 = (LW'(maxy_reg) + LW'(ONE_M1)) >>> FRAC_BITS;
    assign lim = $signed(LW'(eff_side) - LW'(1));
    assign cx0 = (fx0 < 0) ? '0 : fx0;
    assign cy0 = (fy0 < 0) ? '0 : fy0;
    assign cx1 = (fx1 > lim) ? lim : fx1;
    assign cy1 = (fy1 > lim) ? lim : fy1;
    assign box_empty = (eff_side == '0) || (cx0 > cx1) || (cy0 > cy1);

    // ---------------- edge setup operands (doubled units) ----------------
    logic signed [DW-1:0] d_bax, d_bay, d_cax, d_cay, d_cbx, d_cby, d_acx, d_acy;
    logic signed [QW-1:0] ax2, ay2, bx2, by2, cx2, cy2, px0, py0;

    assign d_bax = (DW'(bx_reg) - DW'(ax_reg)) <<< 1;
    assign d_bay = (DW'(by_reg) - DW'(ay_reg)) <<< 1;
    assign d_cax = (DW'(cx_reg) - DW'(ax_reg)) <<< 1;
    assign d_cay = (DW'(cy_reg) - DW'(ay_reg)) <<< 1;
    assign d_cbx = (DW'(cx_reg) - DW'(bx_reg)) <<< 1;
    assign d_cby = (DW'(cy_reg) - DW'(by_reg)) <<< 1;
    assign d_acx = (DW'(ax_reg) - DW'(cx_reg)) <<< 1;
    assign d_acy = (DW'(ay_reg) - DW'(cy_reg)) <<< 1;
    assign ax2   = QW'(ax_reg) <<< 1;
    assign ay2   = QW'(ay_reg) <<< 1;
    assign bx2   = QW'(bx_reg) <<< 1;
    assign by2   = QW'(by_reg) <<< 1;
    assign cx2   = QW'(cx_reg) <<< 1;
    assign cy2   = QW'(cy_reg) <<< 1;
    // texel center of the box origin, (2x+1) << FRAC_BITS
    assign px0   = QW'($signed({1'b0, x0_reg, 1'b1})) <<< FRAC_BITS;
    assign py0   = QW'($signed({1'b0, y_reg, 1'b1})) <<< FRAC_BITS;

    // ---------------- shared multiplier ----------------
    mac_ctl_t             mac_ctl;
    mac_res_t             mac_res;
    logic signed [DW-1:0] mac_a;
    logic signed [QW-1:0] mac_b;
    logic signed [EW-1:0] mac_acc;

    always_comb begin
        mac_ctl.valid = (state_reg == S_SETUP) && !issue_reg[3];
        mac_ctl.first = !issue_reg[0];
        mac_ctl.tag   = issue_reg[2:1];
        unique case (issue_reg[2:0])
            3'd0: begin mac_a = d_bax; mac_b = QW'(d_cay); end
            3'd1: begin mac_a = d_bay; mac_b = QW'(d_cax); end
            3'd2: begin mac_a = d_cbx; mac_b = py0 - by2;  end
            3'd3: begin mac_a = d_cby; mac_b = px0 - bx2;  end
            3'd4: begin mac_a = d_acx; mac_b = py0 - cy2;  end
            3'd5: begin mac_a = d_acy; mac_b = px0 - cx2;  end
            3'd6: begin mac_a = d_bax; mac_b = py0 - ay2;  end
            default: begin mac_a = d_bay; mac_b = px0 - ax2; end
        endcase
    end

    tcr_mac #(
        .DW (DW),
        .QW (QW),
        .EW (EW)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .res     (mac_res),
        .acc     (mac_acc)
    );

    // ---------------- coverage memory ----------------
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [MASK_SIDE-1:0] mem_wdata, mem_rdata;

    tcr_mem #(
        .SIDE (MASK_SIDE)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // ---------------- texel test ----------------
    logic pos_ok, neg_ok, texel_hit;

    assign pos_ok = !cur_reg[0][EW-1] && !cur_reg[1][EW-1] && !cur_reg[2][EW-1];
    assign neg_ok = (cur_reg[0][EW-1] || (cur_reg[0] == '0)) &&
                    (cur_reg[1][EW-1] || (cur_reg[1] == '0)) &&
                    (cur_reg[2][EW-1] || (cur_reg[2] == '0));
    assign texel_hit = area_reg[EW-1] ? neg_ok : pos_ok;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next     = state_reg;
        side_next      = cfg_we ? cfg_wdata : side_reg;
        clr_reply_next = clr_reply_reg;
        clr_row_next   = clr_row_reg;
        issue_next     = issue_reg;
        kind_next      = kind_reg;
        covered_next   = covered_reg;
        col_next       = col_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        minx_next      = minx_reg;
        maxx_next      = maxx_reg;
        miny_next      = miny_reg;
        maxy_next      = maxy_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        area_next      = area_reg;
        mask_next      = mask_reg;
        for (int i = 0; i < 3; i++) begin
            cur_next[i]   = cur_reg[i];
            rs_next[i]    = rs_reg[i];
            xstep_next[i] = xstep_reg[i];
            ystep_next[i] = ystep_reg[i];
        end

        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = y_reg;
        mem_wdata = mem_rdata | mask_reg;
        mem_re    = 1'b0;
        mem_raddr = y_reg;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    kind_next    = s_tuser;
                    covered_next = 1'b0;
                    col_next     = col_ext[AW-1:0];
                    ax_next      = in_ax;
                    ay_next      = in_ay;
                    bx_next      = in_bx;
                    by_next      = in_by;
                    cx_next      = in_cx;
                    cy_next      = in_cy;
                    if (s_tuser == KIND_CLEAR) begin
                        clr_reply_next = 1'b1;
                        clr_row_next   = '0;
                        state_next     = S_CLEAR;
                    end else if (s_tuser == KIND_FILL) begin
                        state_next = S_BOX;
                    end else if ((s_tuser == KIND_READ) && rd_in_range) begin
                        mem_re     = 1'b1;
                        mem_raddr  = row_ext[AW-1:0];
                        state_next = S_READ;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end

            // one row of zeros per cycle
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_row_reg;
                mem_wdata    = '0;
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == AW'(MASK_SIDE - 1)) begin
                    state_next = clr_reply_reg ? S_OUT : S_IDLE;
                end
            end

            // extents and per-texel and per-row edge increments
            S_BOX: begin
                minx_next     = min3(ax_reg, bx_reg, cx_reg);
                maxx_next     = max3(ax_reg, bx_reg, cx_reg);
                miny_next     = min3(ay_reg, by_reg, cy_reg);
                maxy_next     = max3(ay_reg, by_reg, cy_reg);
                xstep_next[0] = -(EW'(d_cby) <<< (FRAC_BITS + 1));
                ystep_next[0] = EW'(d_cbx) <<< (FRAC_BITS + 1);
                xstep_next[1] = -(EW'(d_acy) <<< (FRAC_BITS + 1));
                ystep_next[1] = EW'(d_acx) <<< (FRAC_BITS + 1);
                xstep_next[2] = -(EW'(d_bay) <<< (FRAC_BITS + 1));
                ystep_next[2] = EW'(d_bax) <<< (FRAC_BITS + 1);
                state_next    = S_CLIP;
            end

            S_CLIP: begin
                x0_next    = cx0[AW-1:0];
                x1_next    = cx1[AW-1:0];
                y1_next    = cy1[AW-1:0];
                x_next     = cx0[AW-1:0];
                y_next     = cy0[AW-1:0];
                issue_next = '0;
                state_next = box_empty ? S_OUT : S_SETUP;
            end

            // area and edge values at the box origin through the multiplier
            S_SETUP: begin
                if (!issue_reg[3]) begin
                    issue_next = issue_reg + 1'b1;
                end
                if (mac_res.valid) begin
                    priority case (mac_res.tag)
                        TAG_AREA: area_next = mac_acc;
                        TAG_W0: begin
                            cur_next[0] = mac_acc;
                            rs_next[0]  = mac_acc;
                        end
                        TAG_W1: begin
                            cur_next[1] = mac_acc;
                            rs_next[1]  = mac_acc;
                        end
                        default: begin
                            cur_next[2] = mac_acc;
                            rs_next[2]  = mac_acc;
                            state_next  = (area_reg != '0) ? S_ROWRD : S_OUT;
                        end
                    endcase
                end
            end

            S_ROWRD: begin
                mem_re     = 1'b1;
                mem_raddr  = y_reg;
                mask_next  = '0;
                state_next = S_SCAN;
            end

            // one texel per cycle
            S_SCAN: begin
                if (texel_hit) begin
                    mask_next[x_reg] = 1'b1;
                end
                if (x_reg == x1_reg) begin
                    state_next = S_ROWWR;
                end else begin
                    x_next = x_reg + 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        cur_next[i] = cur_reg[i] + xstep_reg[i];
                    end
                end
            end

            // merge new bits into the row, step to the next row or finish after the last
            S_ROWWR: begin
                mem_we    = 1'b1;
                mem_waddr = y_reg;
                mem_wdata = mem_rdata | mask_reg;
                if (y_reg == y1_reg) begin
                    state_next = S_OUT;
                end else begin
                    y_next     = y_reg + 1'b1;
                    x_next     = x0_reg;
                    state_next = S_ROWRD;
                    for (int i = 0; i < 3; i++) begin
                        rs_next[i]  = rs_reg[i] + ystep_reg[i];
                        cur_next[i] = rs_reg[i] + ystep_reg[i];
                    end
                end
            end

            S_READ: begin
                covered_next = mem_rdata[col_reg];
                state_next   = S_OUT;
            end

            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            side_reg      <= SIDE_RESET;
            clr_reply_reg <= 1'b0;
            clr_row_reg   <= '0;
            issue_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            clr_reply_reg <= clr_reply_next;
            clr_row_reg   <= clr_row_next;
            issue_reg     <= issue_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        covered_reg <= covered_next;
        col_reg     <= col_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        minx_reg    <= minx_next;
        maxx_reg    <= maxx_next;
        miny_reg    <= miny_next;
        maxy_reg    <= maxy_next;
        x0_reg      <= x0_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        area_reg    <= area_next;
        mask_reg    <= mask_next;
        for (int i = 0; i < 3; i++) begin
            cur_reg[i]   <= cur_next[i];
            rs_reg[i]    <= rs_next[i];
            xstep_reg[i] <= xstep_next[i];
            ystep_reg[i] <= ystep_next[i];
        end
    end

    // result channel
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tuser  = kind_reg;
    assign m_tdata  = M_DATA_W'(covered_reg);

    // ---------------- checks ----------------
    `TCR_ASSERT_IMP(a_ready_excl_out, aclk, aresetn, s_tready, !m_tvalid)
    `TCR_ASSERT_IMP(a_mac_only_setup, aclk, aresetn, mac_res.valid, state_reg == S_SETUP)
    `TCR_ASSERT_IMP(a_scan_in_box, aclk, aresetn, state_reg == S_SCAN, (x_reg >= x0_reg) && (x_reg <= x1_reg))
    `TCR_ASSERT_IMP(a_write_states, aclk, aresetn, mem_we, (state_reg == S_ROWWR) || (state_reg == S_CLEAR))
    `TCR_ASSERT_NXT(a_row_end_wb, aclk, aresetn, (state_reg == S_SCAN) && (x_reg == x1_reg), state_reg == S_ROWWR)

endmodule

// File: tb/tcr_coverage_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the side register port, keeps its own copy of the
// coverage mask, predicts one result per accepted transaction and compares.
module tcr_coverage_checker #(
    parameter int MASK_SIDE = 256,
    parameter int FRAC_BITS = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [tcr_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, read_col, read_row
    input  logic [tcr_pkg::S_DATA_W-1:0] s_tdata,
    // kind
    input  logic [tcr_pkg::KIND_W-1:0]   s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    // covered, zero fill
    input  logic [tcr_pkg::M_DATA_W-1:0] m_tdata,
    // done_kind
    input  logic [tcr_pkg::KIND_W-1:0]   m_tuser,
    output int                           mismatches,
    output int                           pending,
    output int                           fills_seen,
    output int                           reads_seen,
    output int                           hits_seen
);
    import tcr_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              covered;
    } tcr_result_t;

    tcr_result_t      due_results[$];
    bit               cov_mask [MASK_SIDE*MASK_SIDE];
    logic [CFG_W-1:0] side_reg = SIDE_RESET;
    int               n_results = 0;

    function automatic longint lo3(input longint a, input longint b, input longint c);
        longint m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic longint hi3(input longint a, input longint b, input longint c);
        longint m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // (b - a) x (p - a)
    function automatic longint edge_val(input longint ax, input longint ay,
                                        input longint bx, input longint by,
                                        input longint px, input longint py);
        return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    // Set every texel whose center lies inside or on the triangle
    task automatic fill_triangle(input logic [S_DATA_W-1:0] data, input int side);
        longint vx [3];
        longint vy [3];
        longint x0, y0, x1, y1, x, y, px, py, area, w0, w1, w2, one;
        int     k;
        bit     hit;
        one = longint'(1) << FRAC_BITS;
        if (side == 0) return;
        for (k = 0; k < 3; k++) begin
            vx[k] = longint'($signed(data[32*k +: 16]));
            vy[k] = longint'($signed(data[32*k+16 +: 16]));
        end
        // floor of the box minimum, ceiling of the maximum, then clip
        x0 = lo3(vx[0], vx[1], vx[2]) >>> FRAC_BITS;
        y0 = lo3(vy[0], vy[1], vy[2]) >>> FRAC_BITS;
        x1 = (hi3(vx[0], vx[1], vx[2]) + one - 1) >>> FRAC_BITS;
        y1 = (hi3(vy[0], vy[1], vy[2]) + one - 1) >>> FRAC_BITS;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > side - 1) x1 = side - 1;
        if (y1 > side - 1) y1 = side - 1;
        if (x0 > x1 || y0 > y1) return;
        // half-fraction units so texel centers land on integers
        for (k = 0; k < 3; k++) begin
            vx[k] = vx[k] * 2;
            vy[k] = vy[k] * 2;
        end
        area = edge_val(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
        if (area == 0) return;
        for (y = y0; y <= y1; y++) begin
            py = (2 * y + 1) * one;
            for (x = x0; x <= x1; x++) begin
                px = (2 * x + 1) * one;
                w0 = edge_val(vx[1], vy[1], vx[2], vy[2], px, py);
                w1 = edge_val(vx[2], vy[2], vx[0], vy[0], px, py);
                w2 = edge_val(vx[0], vy[0], vx[1], vy[1], px, py);
                // either winding; edges count as covered
                hit = (area > 0) ? (w0 >= 0 && w1 >= 0 && w2 >= 0)
                                 : (w0 <= 0 && w1 <= 0 && w2 <= 0);
                if (hit) cov_mask[int'(y) * MASK_SIDE + int'(x)] = 1'b1;
            end
        end
    endtask

    // Update the mask copy and queue the result one transaction causes
    task automatic apply_item(input logic [KIND_W-1:0] kind, input logic [S_DATA_W-1:0] data);
        tcr_result_t r;
        int          side, col, row;
        r.kind    = kind;
        r.covered = 1'b0;
        side = (int'(side_reg) < MASK_SIDE) ? int'(side_reg) : MASK_SIDE;
        case (kind)
            KIND_CLEAR: begin
                foreach (cov_mask[i]) cov_mask[i] = 1'b0;
            end
            KIND_FILL: begin
                fill_triangle(data, side);
                fills_seen <= fills_seen + 1;
            end
            KIND_READ: begin
                col = int'(data[103:96]);
                row = int'(data[111:104]);
                if (col < side && row < side) r.covered = cov_mask[row * MASK_SIDE + col];
                reads_seen <= reads_seen + 1;
                hits_seen  <= hits_seen + (r.covered ? 1 : 0);
            end
            default: ;
        endcase
        due_results.push_back(r);
    endtask

    always @(posedge aclk) begin : watch
        tcr_result_t due;
        int          delta;
        delta = 0;
        if (!aresetn) begin
            side_reg = SIDE_RESET;
            foreach (cov_mask[i]) cov_mask[i] = 1'b0;
            due_results.delete();
        end else begin
            // result side first: it belongs to an earlier transaction
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result %0d arrived with nothing due (kind %0d covered %0d)",
                                 $time, n_results, m_tuser, m_tdata[0]);
                    mismatches <= mismatches + 1;
                end else begin
                    due   = due_results.pop_front();
                    delta = delta - 1;
                    if (m_tuser !== due.kind || m_tdata[0] !== due.covered) begin
                        if (mismatches < 10)
                            $display("%0t: result %0d expected kind %0d covered %0d, got kind %0d covered %0d",
                                     $time, n_results, due.kind, due.covered, m_tuser, m_tdata[0]);
                        mismatches <= mismatches + 1;
                    end
                end
                n_results++;
            end
            if (s_tvalid && s_tready) begin
                apply_item(s_tuser, s_tdata);
                delta = delta + 1;
            end
            if (cfg_we) side_reg = cfg_wdata;
        end
        pending <= pending + delta;
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tcr_pkg::*;

    localparam int MASK_SIDE      = 256;
    localparam int FRAC_BITS      = 4;
    localparam int ITEMS_PER_PASS = 53;
    // must cover a full-mask fill, which runs with no transaction
    localparam int WATCHDOG_LIMIT = 250000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [KIND_W-1:0]   s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]   m_tuser;

    int mismatches, pending, fills_seen, reads_seen, hits_seen;

    // stimulus state
    logic stall_on   = 1'b0;
    int   ready_hold = 0;
    bit   no_idle    = 1'b0;
    int   burst_left = 0;
    int   side_now   = 256;
    int   last_col   = 0;
    int   last_row   = 0;
    int   n_sent     = 0;
    int   n_settings = 0;
    int   pass_sides [8] = '{37, 256, 1, 511, 0, 16, 200, 256};

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    triangle_coverage_rasterizer #(
        .MASK_SIDE (MASK_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    tcr_coverage_checker #(
        .MASK_SIDE (MASK_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending),
        .fills_seen (fills_seen),
        .reads_seen (reads_seen),
        .hits_seen  (hits_seen)
    );

    // Receiver: always ready, or with stall_on alternating ready and stall runs of random length
    always @(posedge aclk) begin
        if (!stall_on) begin
            m_tready <= 1'b1;
        end else if (ready_hold == 0) begin
            m_tready   <= !m_tready;
            ready_hold <= m_tready ? int'($urandom_range(0, 7)) : int'($urandom_range(0, 4));
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    // Triangle payload; read fields carry junk
    function automatic logic [S_DATA_W-1:0] tri_data(input int ax, input int ay,
                                                     input int bx, input int by,
                                                     input int cx, input int cy);
        logic [S_DATA_W-1:0] d;
        d[15:0]    = 16'(ax);
        d[31:16]   = 16'(ay);
        d[47:32]   = 16'(bx);
        d[63:48]   = 16'(by);
        d[79:64]   = 16'(cx);
        d[95:80]   = 16'(cy);
        d[103:96]  = 8'($urandom);
        d[111:104] = 8'($urandom);
        return d;
    endfunction

    // Read payload; vertex fields carry junk
    function automatic logic [S_DATA_W-1:0] read_data(input int col, input int row);
        logic [S_DATA_W-1:0] d;
        d[95:0]    = {$urandom, $urandom, $urandom};
        d[103:96]  = 8'(col);
        d[111:104] = 8'(row);
        return d;
    endfunction

    function automatic logic [S_DATA_W-1:0] noise_data();
        return {$urandom, $urandom, $urandom, 16'($urandom)};
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(0, span)) - span / 5;
    endfunction

    // One transaction, then burst/gap pacing
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [S_DATA_W-1:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
        if (!no_idle) begin
            if (burst_left == 0) begin
                gap        = int'($urandom_range(1, 12));
                burst_left = int'($urandom_range(0, 9));
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Register write once the block has drained and gone idle
    task automatic set_side(input int value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(value);
        @(posedge aclk);
        cfg_we   <= 1'b0;
        side_now  = value;
        n_settings++;
    endtask

    task automatic send_random_item();
        int pick, se, span, bx, by;
        pick = int'($urandom_range(0, 99));
        se   = (side_now == 0 || side_now > MASK_SIDE) ? MASK_SIDE : side_now;
        bx   = int'($urandom_range(0, se - 1)) * 16;
        by   = int'($urandom_range(0, se - 1)) * 16;
        if (pick < 33) begin
            // well-formed triangle near a random texel, mostly small
            span     = (pick < 30) ? 200 : 1100;
            last_col = bx / 16;
            last_row = by / 16;
            send_op(KIND_FILL, tri_data(bx + jitter(span), by + jitter(span),
                                        bx + jitter(span), by + jitter(span),
                                        bx + jitter(span), by + jitter(span)));
        end else if (pick < 73) begin
            send_op(KIND_READ, read_data(last_col + int'($urandom_range(0, 14)) - 2,
                                         last_row + int'($urandom_range(0, 14)) - 2));
        end else if (pick < 88) begin
            send_op(KIND_READ, read_data(int'($urandom_range(0, 255)),
                                         int'($urandom_range(0, 255))));
        end else if (pick < 92) begin
            send_op(KIND_CLEAR, noise_data());
        end else if (pick < 95) begin
            send_op(KIND_UNUSED, noise_data());
        end else if (se <= 64) begin
            // fully random vertices; the box is cheap at this side
            send_op(KIND_FILL, noise_data());
        end else if (pick < 97) begin
            // repeated vertex: zero area
            send_op(KIND_FILL, tri_data(bx, by, bx, by, bx + jitter(200), by + jitter(200)));
        end else begin
            // box entirely left of the mask
            send_op(KIND_FILL, tri_data(-16 * int'($urandom_range(2, 2000)), by,
                                        -16 * int'($urandom_range(2, 2000)), by + jitter(200),
                                        -32, by + jitter(200)));
        end
    endtask

    // Watchdog: too long without any transaction
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("no transaction for %0d cycles, %0d results outstanding", quiet, pending);
        $display("triangle_coverage_rasterizer: mismatch");
        $finish;
    end

    initial begin : stimulus
        int p;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // clearing pass after reset
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        set_side(256);

        // basic fills, both windings, degenerate and off-mask boxes
        send_op(KIND_READ, read_data(0, 0));
        send_op(KIND_FILL, tri_data(16, 16, 112, 16, 16, 112));
        send_op(KIND_READ, read_data(2, 2));
        send_op(KIND_FILL, tri_data(160, 160, 160, 256, 256, 160));
        send_op(KIND_READ, read_data(10, 10));
        send_op(KIND_FILL, tri_data(320, 320, 480, 480, 640, 640));
        send_op(KIND_READ, read_data(25, 25));
        send_op(KIND_FILL, tri_data(-800, -800, -400, -800, -800, -400));
        send_op(KIND_FILL, tri_data(5000, 5000, 6000, 5000, 5000, 6000));
        // extreme vertices: box clips to the whole mask
        send_op(KIND_FILL, tri_data(32767, 32767, -32768, 32767, 32767, -32768));
        send_op(KIND_READ, read_data(255, 255));
        send_op(KIND_READ, read_data(0, 255));
        send_op(KIND_UNUSED, '1);
        send_op(KIND_CLEAR, '0);
        send_op(KIND_READ, read_data(2, 2));

        // bits survive a side change; a clear wipes beyond the active square
        send_op(KIND_FILL, tri_data(1600, 1600, 1760, 1600, 1600, 1760));
        set_side(50);
        send_op(KIND_READ, read_data(100, 100));
        send_op(KIND_FILL, tri_data(640, 640, 1200, 640, 640, 1200));
        set_side(511);
        send_op(KIND_READ, read_data(100, 100));
        send_op(KIND_READ, read_data(49, 41));
        set_side(50);
        send_op(KIND_CLEAR, '0);
        set_side(256);
        send_op(KIND_READ, read_data(100, 100));

        // side zero, then side one
        set_side(0);
        send_op(KIND_FILL, tri_data(0, 0, 800, 0, 0, 800));
        send_op(KIND_READ, read_data(0, 0));
        set_side(1);
        send_op(KIND_FILL, tri_data(0, 0, 800, 0, 0, 800));
        send_op(KIND_READ, read_data(0, 0));
        send_op(KIND_READ, read_data(1, 0));

        // random passes, each at its own side and pacing
        for (p = 0; p < 8; p++) begin
            set_side((p == 7) ? int'($urandom_range(1, 511)) : pass_sides[p]);
            stall_on <= ($urandom_range(0, 3) != 0);
            no_idle   = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PASS) send_random_item();
        end

        // drain
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        $display("sent %0d transactions: %0d fills, %0d reads with %0d covered texels",
                 n_sent, fills_seen, reads_seen, hits_seen);
        $display("side register written %0d times, from 0 and 1 up to 511", n_settings);
        if (mismatches == 0 && pending == 0) begin
            $display("triangle_coverage_rasterizer: match");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches, pending);
            $display("triangle_coverage_rasterizer: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/tcr_pkg.sv
rtl/tcr_mac.sv
rtl/tcr_mem.sv
rtl/triangle_coverage_rasterizer.sv
tb/tcr_coverage_checker.sv
tb/tb_top.sv
